[hdl/dtde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtde_pkg
// field widths, default geometry and the tile record shared by the enumerator
// ----------------------------------------------------------------------------
package dtde_pkg;

  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 7;
  localparam int BASE_W      = 11;
  localparam int BMCOL_W     = 6;
  localparam int TROW_W      = 4;
  localparam int WCOL_W      = 11;

  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int TILE_PIXELS_DEF    = 16;
  localparam int BITMAP_COLUMNS_DEF = 44;
  localparam int BITMAP_ROWS_DEF    = 16;

  typedef struct packed {
    logic [BMCOL_W-1:0] bitmap_column;
    logic [TROW_W-1:0]  tile_row;
    logic [WCOL_W-1:0]  world_column;
  } tile_t;

endpackage

[hdl/dirty_tile_dedup_enumerator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_tile_dedup_enumerator
// lists the bitmap tiles a stale rectangle touches, once per frame each
// ----------------------------------------------------------------------------
// Each input transaction is one rectangle; the block answers with one output
// transaction per tile that is inside the bitmap window and not yet emitted in
// this frame, column by column, the final one flagged by last_o. The seen map
// is a ram of one row of BITMAP_COLUMNS bits per tile row, with a valid flop
// per row, so first_of_frame_i clears it at once and no clearing pass follows
// reset. The four tile bounds share one reciprocal multiplier and each goes
// through a magnitude, a multiply and a correction state. The walk then steps
// past each tile column and each row outside the window; a tile in the window
// is read from the ram, then checked and written back. At most MAX_RESULTS
// tiles are listed per rectangle. A closing state passes the last tile to the
// output and the idle state takes the next rectangle. Output stalls hold the
// walk only while a tile waits to move into the held output register.
// The next rectangle is taken once the previous one's last tile is in the
// output register.
module dirty_tile_dedup_enumerator import dtde_pkg::*; #(
  parameter int TILE_PIXELS    = TILE_PIXELS_DEF,
  parameter int BITMAP_COLUMNS = BITMAP_COLUMNS_DEF,
  parameter int BITMAP_ROWS    = BITMAP_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] left_x_i,
  input  logic [COORD_W-1:0] top_y_i,
  input  logic [SIZE_W-1:0]  width_px_i,
  input  logic [SIZE_W-1:0]  height_px_i,
  input  logic [BASE_W-1:0]  base_column_i,
  input  logic               first_of_frame_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BMCOL_W-1:0] bitmap_column_o,
  output logic [TROW_W-1:0]  tile_row_o,
  output logic [WCOL_W-1:0]  world_column_o,
  output logic               last_o
);

  // coordinate sums and division by the tile size
  localparam int POS_W     = COORD_W + 1;
  localparam int ABS_W     = COORD_W;
  localparam int DIV_SHIFT = ABS_W + 1;
  localparam int TP_LOG    = $clog2(TILE_PIXELS);
  localparam int RECIP_W   = DIV_SHIFT - TP_LOG + 1;
  localparam int QU_W      = ABS_W + 1 - TP_LOG;
  localparam int PROD_W    = ABS_W + RECIP_W;
  localparam int TP_W      = $clog2(TILE_PIXELS + 1);
  localparam int TIDX_W    = QU_W + 1;
  localparam int DIFF_W    = TIDX_W + 1;
  localparam int COL_W     = (BITMAP_COLUMNS > 1) ? $clog2(BITMAP_COLUMNS) : 1;
  localparam int ROW_W     = (BITMAP_ROWS > 1) ? $clog2(BITMAP_ROWS) : 1;

  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'((64'd1 << DIV_SHIFT) / TILE_PIXELS);
  localparam logic [TP_W-1:0]    TILE_V  = TP_W'(TILE_PIXELS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV_ABS = 3'd1;
  localparam logic [2:0] S_DIV_MUL = 3'd2;
  localparam logic [2:0] S_DIV_FIX = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;
  localparam logic [2:0] S_CHECK   = 3'd5;
  localparam logic [2:0] S_FLUSH   = 3'd6;

  localparam logic [1:0] OP_LEFT   = 2'd0;
  localparam logic [1:0] OP_RIGHT  = 2'd1;
  localparam logic [1:0] OP_TOP    = 2'd2;
  localparam logic [1:0] OP_BOTTOM = 2'd3;

  logic [2:0]               state_q, state_d;
  logic [COORD_W-1:0]       x_q, x_d, y_q, y_d;
  logic [SIZE_W-1:0]        w_q, w_d, h_q, h_d;
  logic [BASE_W-1:0]        base_q, base_d;
  logic [1:0]               div_op_q, div_op_d;
  logic [ABS_W-1:0]         div_abs_q, div_abs_d;
  logic                     div_neg_q, div_neg_d;
  logic [QU_W-1:0]          div_qest_q, div_qest_d;
  logic signed [TIDX_W-1:0] tx_q, tx_d, tx1_q, tx1_d;
  logic signed [TIDX_W-1:0] ty_q, ty_d, ty0_q, ty0_d, ty1_q, ty1_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [BITMAP_ROWS-1:0]   row_valid_q, row_valid_d;
  tile_t                    pend_tile_q, pend_tile_d;
  logic                     pend_valid_q, pend_valid_d;
  tile_t                    out_tile_q, out_tile_d;
  logic                     out_last_q, out_last_d;
  logic                     out_valid_q, out_valid_d;

  logic                      in_accept;
  logic                      out_busy;
  logic                      out_load;
  logic [POS_W-1:0]          opnd;
  logic [POS_W-1:0]          opnd_mag;
  logic [PROD_W-1:0]         div_prod;
  logic [ABS_W-1:0]          div_back;
  logic [ABS_W:0]            div_rem;
  logic [QU_W-1:0]           div_quot;
  logic signed [TIDX_W-1:0]  div_bound;
  logic signed [DIFF_W-1:0]  col_diff;
  logic                      col_in, row_in, col_done, row_done;
  logic [COL_W-1:0]          col_idx;
  logic [ROW_W-1:0]          row_idx;
  logic [BITMAP_COLUMNS-1:0] ram_rdata, row_cur, row_new;
  logic                      ram_re, ram_we;
  logic                      seen_bit;
  tile_t                     cur_tile;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;

  // bound operand and its magnitude
  always_comb begin
    case (div_op_q)
      OP_LEFT:   opnd = {x_q[COORD_W-1], x_q};
      OP_RIGHT:  opnd = {x_q[COORD_W-1], x_q} + POS_W'(w_q) - POS_W'(1);
      OP_TOP:    opnd = {y_q[COORD_W-1], y_q};
      OP_BOTTOM: opnd = {y_q[COORD_W-1], y_q} + POS_W'(h_q) - POS_W'(1);
      default:   opnd = '0;
    endcase
    opnd_mag = opnd[POS_W-1] ? (~opnd + POS_W'(1)) : opnd;
  end

  // reciprocal estimate is low by at most one, the remainder fixes it
  assign div_prod  = div_abs_q * RECIP_V;
  assign div_back  = ABS_W'(div_qest_q * TILE_V);
  assign div_rem   = {1'b0, div_abs_q} - {1'b0, div_back};
  assign div_quot  = div_qest_q + QU_W'(div_rem >= (ABS_W + 1)'(TILE_PIXELS));
  assign div_bound = div_neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

  // current tile position
  assign col_diff = $signed({tx_q[TIDX_W-1], tx_q})
                  - $signed({{(DIFF_W - BASE_W){1'b0}}, base_q});
  assign col_in   = !col_diff[DIFF_W-1] && (col_diff < $signed(DIFF_W'(BITMAP_COLUMNS)));
  assign row_in   = !ty_q[TIDX_W-1] && (ty_q < $signed(TIDX_W'(BITMAP_ROWS)));
  assign col_done = (tx_q > tx1_q);
  assign row_done = (ty_q > ty1_q);
  assign col_idx  = col_diff[COL_W-1:0];
  assign row_idx  = ty_q[ROW_W-1:0];

  assign row_cur  = row_valid_q[row_idx] ? ram_rdata : '0;
  assign seen_bit = row_cur[col_idx];
  assign row_new  = row_cur | (BITMAP_COLUMNS'(1) << col_idx);

  assign cur_tile.bitmap_column = BMCOL_W'(col_diff);
  assign cur_tile.tile_row      = TROW_W'(ty_q);
  assign cur_tile.world_column  = WCOL_W'(tx_q);

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    w_d          = w_q;
    h_d          = h_q;
    base_d       = base_q;
    div_op_d     = div_op_q;
    div_abs_d    = div_abs_q;
    div_neg_d    = div_neg_q;
    div_qest_d   = div_qest_q;
    tx_d         = tx_q;
    tx1_d        = tx1_q;
    ty_d         = ty_q;
    ty0_d        = ty0_q;
    ty1_d        = ty1_q;
    cnt_d        = cnt_q;
    row_valid_d  = row_valid_q;
    pend_tile_d  = pend_tile_q;
    pend_valid_d = pend_valid_q;
    out_tile_d   = out_tile_q;
    out_last_d   = out_last_q;
    out_load     = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          x_d      = left_x_i;
          y_d      = top_y_i;
          w_d      = width_px_i;
          h_d      = height_px_i;
          base_d   = base_column_i;
          div_op_d = OP_LEFT;
          cnt_d    = '0;
          if (first_of_frame_i) begin
            row_valid_d = '0;
          end
          state_d = S_DIV_ABS;
        end
      end
      S_DIV_ABS: begin
        div_abs_d = opnd_mag[ABS_W-1:0];
        div_neg_d = opnd[POS_W-1];
        state_d   = S_DIV_MUL;
      end
      S_DIV_MUL: begin
        div_qest_d = div_prod[DIV_SHIFT +: QU_W];
        state_d    = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        div_op_d = div_op_q + 2'd1;
        state_d  = S_DIV_ABS;
        case (div_op_q)
          OP_LEFT:   tx_d  = div_bound;
          OP_RIGHT:  tx1_d = div_bound;
          OP_TOP:    ty0_d = div_bound;
          OP_BOTTOM: begin
            ty1_d   = div_bound;
            ty_d    = ty0_q;
            state_d = S_WALK;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_WALK: begin
        if (col_done || (cnt_q == CNT_W'(MAX_RESULTS))) begin
          state_d = S_FLUSH;
        end else if (!col_in || row_done) begin
          tx_d = tx_q + TIDX_W'(1);
          ty_d = ty0_q;
        end else if (!row_in) begin
          ty_d = ty_q + TIDX_W'(1);
        end else begin
          ram_re  = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (seen_bit) begin
          ty_d    = ty_q + TIDX_W'(1);
          state_d = S_WALK;
        end else if (!(pend_valid_q && out_busy)) begin
          ram_we               = 1'b1;
          row_valid_d[row_idx] = 1'b1;
          if (pend_valid_q) begin
            out_load   = 1'b1;
            out_tile_d = pend_tile_q;
            out_last_d = 1'b0;
          end
          pend_tile_d  = cur_tile;
          pend_valid_d = 1'b1;
          cnt_d        = cnt_q + CNT_W'(1);
          ty_d         = ty_q + TIDX_W'(1);
          state_d      = S_WALK;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (!out_busy) begin
          out_load     = 1'b1;
          out_tile_d   = pend_tile_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      div_op_q     <= OP_LEFT;
      cnt_q        <= '0;
      row_valid_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      div_op_q     <= div_op_d;
      cnt_q        <= cnt_d;
      row_valid_q  <= row_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    w_q         <= w_d;
    h_q         <= h_d;
    base_q      <= base_d;
    div_abs_q   <= div_abs_d;
    div_neg_q   <= div_neg_d;
    div_qest_q  <= div_qest_d;
    tx_q        <= tx_d;
    tx1_q       <= tx1_d;
    ty_q        <= ty_d;
    ty0_q       <= ty0_d;
    ty1_q       <= ty1_d;
    pend_tile_q <= pend_tile_d;
    out_tile_q  <= out_tile_d;
    out_last_q  <= out_last_d;
  end

  // seen map, one row of tile bits per address
  dtde_ram #(
    .WIDTH (BITMAP_COLUMNS),
    .DEPTH (BITMAP_ROWS),
    .ADDR_W(ROW_W)
  ) u_seen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(row_idx),
    .wdata_i(row_new),
    .re_i   (ram_re),
    .raddr_i(row_idx),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign bitmap_column_o = out_tile_q.bitmap_column;
  assign tile_row_o      = out_tile_q.tile_row;
  assign world_column_o  = out_tile_q.world_column;
  assign last_o          = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("tile count beyond result limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_busy)
    else $error("output register loaded while held");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && first_of_frame_i |=> row_valid_q == '0)
    else $error("seen map not cleared at frame start");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q)
    else $error("pending tile left behind at idle");

endmodule

[hdl/dtde_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtde_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module dtde_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dirty tile enumerator
// ----------------------------------------------------------------------------
// A queue of rectangles feeds a clocked driver. The driver offers them with
// random gaps, and the receiver stalls at random. The bench tracks its own
// copy of the per-frame seen map and works out, for every accepted rectangle,
// the tiles it must produce: column-major walk, window clipping, de-duplication
// within a frame and the cap on tiles per rectangle. Each output transaction
// is checked against the oldest tile still due. The run starts with directed
// corner cases, then goes through four idle and stall settings with random
// frames of rectangles. In the first setting the receiver holds off for a long
// stretch so that the enumerator backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import dtde_pkg::*;

  localparam int TILE_PX     = TILE_PIXELS_DEF;
  localparam int MAP_COLS    = BITMAP_COLUMNS_DEF;
  localparam int MAP_ROWS    = BITMAP_ROWS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] top_y;
    logic [SIZE_W-1:0]  width_px;
    logic [SIZE_W-1:0]  height_px;
    logic [BASE_W-1:0]  base_column;
    logic               first_of_frame;
  } rect_t;

  typedef struct {
    tile_t tile;
    logic  last;
  } due_tile_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [COORD_W-1:0] left_x_i = '0;
  logic [COORD_W-1:0] top_y_i = '0;
  logic [SIZE_W-1:0]  width_px_i = '0;
  logic [SIZE_W-1:0]  height_px_i = '0;
  logic [BASE_W-1:0]  base_column_i = '0;
  logic               first_of_frame_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [BMCOL_W-1:0] bitmap_column_o;
  logic [TROW_W-1:0]  tile_row_o;
  logic [WCOL_W-1:0]  world_column_o;
  logic               last_o;

  rect_t       rects_to_send[$];
  due_tile_t   tiles_due[$];
  logic [MAP_COLS*MAP_ROWS-1:0] painted_map = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_out = 1'b0;
  logic        pressure_go = 1'b0;
  logic        rect_taken = 1'b0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          frame_base = 0;

  dirty_tile_dedup_enumerator dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // walk the tiles of one rectangle and queue the ones still to repaint
  function automatic void enumerate_rect(input rect_t r);
    int x, y, w, h, base, tx, ty, tx1, ty1, col, n;
    due_tile_t t;
    x = $signed(r.left_x);
    y = $signed(r.top_y);
    w = r.width_px;
    h = r.height_px;
    base = r.base_column;
    n = 0;
    if (r.first_of_frame) painted_map = '0;
    tx1 = (x + w - 1) / TILE_PX;
    ty1 = (y + h - 1) / TILE_PX;
    for (tx = x / TILE_PX; tx <= tx1 && n < MAX_RESULTS; tx++) begin
      col = tx - base;
      if (col < 0 || col >= MAP_COLS) continue;
      for (ty = y / TILE_PX; ty <= ty1 && n < MAX_RESULTS; ty++) begin
        if (ty < 0 || ty >= MAP_ROWS) continue;
        if (painted_map[ty * MAP_COLS + col]) continue;
        painted_map[ty * MAP_COLS + col] = 1'b1;
        t.tile.bitmap_column = col[BMCOL_W-1:0];
        t.tile.tile_row = ty[TROW_W-1:0];
        t.tile.world_column = tx[WCOL_W-1:0];
        t.last = 1'b0;
        tiles_due.push_back(t);
        n++;
      end
    end
    if (n > 0) begin
      t = tiles_due.pop_back();
      t.last = 1'b1;
      tiles_due.push_back(t);
    end
  endfunction

  task automatic add_rect(input int x, input int y, input int w, input int h,
                          input int base, input logic fof);
    rect_t r;
    r.left_x = x[COORD_W-1:0];
    r.top_y = y[COORD_W-1:0];
    r.width_px = w[SIZE_W-1:0];
    r.height_px = h[SIZE_W-1:0];
    r.base_column = base[BASE_W-1:0];
    r.first_of_frame = fof;
    rects_to_send.push_back(r);
  endtask

  function automatic int random_size();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return $urandom_range(127);
    if (pick < 4) return $urandom_range(112, 1);
    return $urandom_range(40, 1);
  endfunction

  // frames of rectangles around the visible window, with some noise mixed in
  task automatic queue_random_rects(input int count);
    int pick;
    logic fof;
    repeat (count) begin
      fof = 1'b0;
      if ($urandom_range(11) == 0) begin
        fof = 1'b1;
        pick = $urandom_range(9);
        frame_base = (pick == 0) ? 2047 : (pick == 1) ? 0 : $urandom_range(2000);
      end
      if ($urandom_range(6) == 0) begin
        add_rect($urandom, $urandom, $urandom_range(127), $urandom_range(127),
                 $urandom_range(2047), fof | ($urandom_range(9) == 0));
      end else begin
        add_rect(frame_base * TILE_PX + int'($urandom_range(800)) - 48,
                 int'($urandom_range(300)) - 48, random_size(), random_size(),
                 frame_base, fof);
      end
    end
  endtask

  always @(negedge clk_i) begin : drive_rects
    rect_t nxt;
    if (rst_ni && (!in_valid_i || rect_taken)) begin
      if (rects_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = rects_to_send.pop_front();
        in_valid_i <= 1'b1;
        left_x_i <= nxt.left_x;
        top_y_i <= nxt.top_y;
        width_px_i <= nxt.width_px;
        height_px_i <= nxt.height_px;
        base_column_i <= nxt.base_column;
        first_of_frame_i <= nxt.first_of_frame;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_out || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : watch_ports
    rect_t acc;
    due_tile_t want;
    rect_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (tiles_due.size() == 0) begin
          report_mismatch($sformatf("unexpected tile col %0d row %0d world %0d last %0b",
                                    bitmap_column_o, tile_row_o, world_column_o, last_o));
        end else begin
          want = tiles_due.pop_front();
          if (bitmap_column_o !== want.tile.bitmap_column ||
              tile_row_o !== want.tile.tile_row ||
              world_column_o !== want.tile.world_column ||
              last_o !== want.last) begin
            report_mismatch($sformatf(
              "tile got col %0d row %0d world %0d last %0b, want %0d %0d %0d %0b",
              bitmap_column_o, tile_row_o, world_column_o, last_o,
              want.tile.bitmap_column, want.tile.tile_row, want.tile.world_column,
              want.last));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        rect_taken = 1'b1;
        acc.left_x = left_x_i;
        acc.top_y = top_y_i;
        acc.width_px = width_px_i;
        acc.height_px = height_px_i;
        acc.base_column = base_column_i;
        acc.first_of_frame = first_of_frame_i;
        enumerate_rect(acc);
      end
    end
  end

  // receiver holds off long enough for the enumerator to back up
  initial begin : long_hold
    int held;
    wait (pressure_go);
    @(posedge clk_i);
    hold_out = 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
    hold_out = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners
    add_rect(0, 0, 1, 1, 0, 1'b1);
    add_rect(0, 0, 1, 1, 0, 1'b0);
    add_rect(-1, -1, 2, 2, 0, 1'b1);
    add_rect(-17, -17, 1, 1, 0, 1'b0);
    add_rect(16, 0, 0, 0, 0, 1'b0);
    add_rect(17, 17, 0, 0, 0, 1'b0);
    add_rect(0, 0, 127, 127, 0, 1'b1);
    add_rect(32767, 0, 127, 127, 2047, 1'b1);
    add_rect(-32768, -32768, 127, 127, 0, 1'b1);
    add_rect(43 * TILE_PX, 15 * TILE_PX, 32, 32, 0, 1'b1);
    add_rect(44 * TILE_PX, 0, 16, 1, 0, 1'b0);
    add_rect(5 * TILE_PX, 3 * TILE_PX, 112, 112, 2047, 1'b0);
    add_rect(-1, 32767, 1, 1, 0, 1'b0);
    add_rect(1000 * TILE_PX + 8, 100, 40, 30, 1000, 1'b1);
    add_rect(1001 * TILE_PX + 8, 90, 40, 30, 1000, 1'b0);
    add_rect(0, 0, 112, 112, 0, 1'b1);
    add_rect(8, 8, 112, 112, 0, 1'b0);

    // no idling, with one long receiver hold
    queue_random_rects(110);
    pressure_go = 1'b1;
    while (rects_to_send.size() != 0) @(posedge clk_i);

    sender_idle_pct = 58;
    queue_random_rects(110);
    while (rects_to_send.size() != 0) @(posedge clk_i);

    sender_idle_pct = 0;
    recv_stall_pct = 58;
    queue_random_rects(110);
    while (rects_to_send.size() != 0) @(posedge clk_i);

    sender_idle_pct = 37;
    recv_stall_pct = 37;
    queue_random_rects(120);

    while (rects_to_send.size() != 0 || in_valid_i || tiles_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tiles_due.size() != 0)
      report_mismatch($sformatf("%0d tiles never produced", tiles_due.size()));
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
